// ===== rtl/core/five_bit_text_packer_top_assert.svh =====
// assertion macros for the five-bit text packer
// used by five_bit_text_packer_top; needs nothing else
`ifndef FIVE_BIT_TEXT_PACKER_TOP_ASSERT_SVH
`define FIVE_BIT_TEXT_PACKER_TOP_ASSERT_SVH

// condition in the same cycle
`define FBTP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in the next cycle
`define FBTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fbtp_pkg.sv =====
// shared types, constants and code table for the five-bit text packer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbtp_pkg;

   // widths of the coded stream
   localparam int NUMBER_BITS = 10;
   localparam int CODE_BITS   = 5;
   localparam int PEND_BITS   = 7;
   localparam int MAX_BITS    = PEND_BITS + 2 * CODE_BITS + NUMBER_BITS;
   localparam int MAX_BYTES   = (MAX_BITS + 7) / 8;
   localparam int ACC_W       = MAX_BYTES * 8;
   localparam int LEN_W       = $clog2(ACC_W + 1);
   localparam int CNT_W       = $clog2(MAX_BYTES + 1);
   localparam int NUM_SEG_W   = CODE_BITS + NUMBER_BITS;

   // fixed codes
   localparam logic [CODE_BITS-1:0] ESCAPE_CODE = 5'b11111;
   localparam logic [CODE_BITS-1:0] LETTER_BASE = 5'b00000;
   localparam logic [CODE_BITS-1:0] SPACE_CODE  = 5'b11011;
   localparam logic [CODE_BITS-1:0] COMMA_CODE  = 5'b11100;
   localparam logic [CODE_BITS-1:0] PERIOD_CODE = 5'b11101;
   localparam logic [CODE_BITS-1:0] QUOTE_CODE  = 5'b11110;

   // ascii characters of interest
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COMMA   = 8'h2c;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2e;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
   } sym_code_type;

   // bytes handed from the encoder to the serializer
   typedef struct packed {
      logic [ACC_W-1:0] word;   // left aligned, first byte at the top
      logic [CNT_W-1:0] count;  // number of bytes in word
      logic             done;   // last byte ends the text
   } job_type;

   // code of a text byte, invalid when the byte has none
   function automatic sym_code_type symbol_code(input logic [7:0] c);
      sym_code_type r;
      r.valid = 1'b1;
      r.code  = LETTER_BASE;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r.code = CODE_BITS'(c - CHAR_LOWER_A);
      end else if (c == CHAR_SPACE) begin
         r.code = SPACE_CODE;
      end else if (c == CHAR_COMMA) begin
         r.code = COMMA_CODE;
      end else if (c == CHAR_PERIOD) begin
         r.code = PERIOD_CODE;
      end else if (c == CHAR_QUOTE) begin
         r.code = QUOTE_CODE;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbtp_encoder.sv =====
// symbol encoder: number collection, bit packing state, byte job forming
// depends on fbtp_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbtp_encoder (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      symbol,
   input  wire logic            end_of_text,
   output fbtp_pkg::job_type    job
);

   logic [fbtp_pkg::PEND_BITS-1:0]   pend_bits_ff, pend_bits_in;
   logic [2:0]                       pend_count_ff, pend_count_in;
   logic [fbtp_pkg::NUMBER_BITS-1:0] num_value_ff, num_value_in;
   logic                             num_active_ff, num_active_in;

   logic                             is_digit;
   logic [3:0]                       digit;
   logic [fbtp_pkg::NUMBER_BITS+3:0] num_prod;
   logic [fbtp_pkg::NUMBER_BITS-1:0] num_next;
   logic                             do_flush;
   fbtp_pkg::sym_code_type           sym;
   logic [fbtp_pkg::NUM_SEG_W-1:0]   num_seg;
   logic [fbtp_pkg::ACC_W-1:0]       acc;
   logic [fbtp_pkg::LEN_W-1:0]       len;
   logic [2:0]                       pad;
   logic [2:0]                       rem;
   logic [fbtp_pkg::LEN_W-1:0]       align;

   // digit classification and value update (times ten by shift and add)
   always_comb begin
      is_digit = (symbol >= fbtp_pkg::CHAR_ZERO) && (symbol <= fbtp_pkg::CHAR_NINE);
      digit    = 4'(symbol - fbtp_pkg::CHAR_ZERO);
      num_prod = {1'b0, num_value_ff, 3'b000}
               + {3'b000, num_value_ff, 1'b0}
               + (fbtp_pkg::NUMBER_BITS + 4)'(digit);
      num_next = fbtp_pkg::NUMBER_BITS'(num_prod);
      sym      = fbtp_pkg::symbol_code(symbol);
   end

   // build the bit string of this request
   always_comb begin
      do_flush = is_digit ? end_of_text : num_active_ff;
      num_seg  = {fbtp_pkg::ESCAPE_CODE, (is_digit ? num_next : num_value_ff)};
      acc      = fbtp_pkg::ACC_W'(pend_bits_ff);
      len      = fbtp_pkg::LEN_W'(pend_count_ff);
      if (do_flush) begin
         acc = (acc << fbtp_pkg::NUM_SEG_W) | fbtp_pkg::ACC_W'(num_seg);
         len = len + fbtp_pkg::LEN_W'(fbtp_pkg::NUM_SEG_W);
      end
      if (!is_digit && sym.valid) begin
         acc = (acc << fbtp_pkg::CODE_BITS) | fbtp_pkg::ACC_W'(sym.code);
         len = len + fbtp_pkg::LEN_W'(fbtp_pkg::CODE_BITS);
      end
      pad = 3'(4'd8 - {1'b0, len[2:0]});
      if (end_of_text) begin
         acc = acc << pad;
         len = len + fbtp_pkg::LEN_W'(pad);
      end
      rem       = len[2:0];
      align     = fbtp_pkg::LEN_W'(fbtp_pkg::ACC_W) - len;
      job.word  = acc << align;
      job.count = fbtp_pkg::CNT_W'(len[fbtp_pkg::LEN_W-1:3]);
      job.done  = end_of_text;
   end

   // next packing and number state
   always_comb begin
      pend_bits_in  = fbtp_pkg::PEND_BITS'(acc)
                    & fbtp_pkg::PEND_BITS'((8'd1 << rem) - 8'd1);
      pend_count_in = rem;
      num_value_in  = num_value_ff;
      num_active_in = num_active_ff;
      if (is_digit) begin
         num_value_in  = num_next;
         num_active_in = 1'b1;
      end
      if (do_flush || end_of_text) begin
         num_value_in  = '0;
         num_active_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         num_value_ff  <= '0;
         num_active_ff <= 1'b0;
      end else if (accept) begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         num_value_ff  <= num_value_in;
         num_active_ff <= num_active_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/five_bit_text_packer_top.sv =====
// five-bit text packer top level: request stream in, packed byte stream out
// depends on fbtp_pkg, fbtp_encoder and five_bit_text_packer_top_assert.svh
// a request is accepted into the byte job register; its first packed byte then goes through the output register
// throughput: one byte per cycle while rsp_tready is high; a request making n bytes (0..4) holds the job
// register until its last byte moves, and the next request can be accepted as that last byte moves
// reset: synchronous active high, clears packing state, number and both stages
`timescale 1ns / 1ps
`default_nettype none

`include "five_bit_text_packer_top_assert.svh"

module five_bit_text_packer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol
   input  wire logic       req_tlast,   // end_of_text
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] packed_byte
   output      logic       rsp_tlast,   // last_of_run
   output      logic       rsp_tuser    // [0] stream_done
);

   fbtp_pkg::job_type                new_job;
   logic [fbtp_pkg::ACC_W-1:0]       job_word_ff;
   logic [fbtp_pkg::CNT_W-1:0]       job_count_ff;
   logic                             job_done_ff;
   logic                             rsp_valid_ff;
   logic [7:0]                       rsp_data_ff;
   logic                             rsp_last_ff;
   logic                             rsp_done_ff;
   logic                             accept;
   logic                             move;
   logic                             job_final;

   fbtp_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .symbol      (req_tdata),
      .end_of_text (req_tlast),
      .job         (new_job)
   );

   // handshake control
   always_comb begin
      job_final  = (job_count_ff == fbtp_pkg::CNT_W'(1));
      move       = (job_count_ff != '0) && (!rsp_valid_ff || rsp_tready);
      req_tready = (job_count_ff == '0) || (job_final && move);
      accept     = req_tvalid && req_tready;
   end

   // byte job register
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
      end else if (accept) begin
         job_word_ff  <= new_job.word;
         job_count_ff <= new_job.count;
         job_done_ff  <= new_job.done;
      end else if (move) begin
         job_word_ff  <= job_word_ff << 8;
         job_count_ff <= job_count_ff - fbtp_pkg::CNT_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= job_word_ff[fbtp_pkg::ACC_W-1 -: 8];
         rsp_last_ff  <= job_final;
         rsp_done_ff  <= job_final && job_done_ff;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   // checks
   `FBTP_ASSERT_SAME(a_busy_no_ready, clock, reset,
      job_count_ff > fbtp_pkg::CNT_W'(1), !req_tready,
      "request taken while byte job still busy")
   `FBTP_ASSERT_SAME(a_done_is_last, clock, reset,
      rsp_tvalid && rsp_tuser, rsp_tlast,
      "stream done without last of run")
   `FBTP_ASSERT_NEXT(a_end_marks_job, clock, reset,
      accept && req_tlast && new_job.count != '0, job_done_ff,
      "end of text not carried into byte job")
   `FBTP_ASSERT_SAME(a_count_range, clock, reset,
      1'b1, job_count_ff <= fbtp_pkg::CNT_W'(fbtp_pkg::MAX_BYTES),
      "byte job count out of range")

endmodule

`default_nettype wire
